FILE: hdl/kmdb_pkg.sv
// Shared types and constants of the key matrix debounce engine.
`timescale 1ns / 1ps

package kmdb_pkg;

  // Width of the key position field and count of positions it can name
  localparam int unsigned PosW         = 8;
  localparam int unsigned NumPositions = 256;
  localparam int unsigned CodeW        = 8;

  // Debounce thresholds on the signed per-key counter
  localparam logic signed [7:0] DebLimit  = 8'sd4;
  localparam logic signed [7:0] DebHold   = 8'sd8;
  localparam logic signed [7:0] CountIdle = -8'sd1;
  localparam logic signed [7:0] CountZero = 8'sd0;
  localparam logic signed [7:0] CountOne  = 8'sd1;

  // Per-key state word kept in the state RAM
  typedef struct packed {
    logic signed [7:0] count;
    logic              prev;
    logic [CodeW-1:0]  saved;
  } kmdb_state_t;

  // One result word
  typedef struct packed {
    logic             held;
    logic             mk;
    logic             brk;
    logic [CodeW-1:0] code;
  } kmdb_result_t;

  localparam kmdb_state_t StateReset = '{count: -8'sd1, prev: 1'b0, saved: '0};

endpackage

FILE: hdl/kmdb_state_ram.sv
// Per-key state RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module kmdb_state_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  kmdb_pkg::kmdb_state_t wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output kmdb_pkg::kmdb_state_t rdata_o
);
  import kmdb_pkg::*;

  kmdb_state_t mem [Depth];
  kmdb_state_t rdata_q;

  // Write the committed state word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read on accept; hold the read word otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/kmdb_step.sv
// Debounce update: next key state and result word from one key sample.
`timescale 1ns / 1ps

module kmdb_step (
  input  logic                  report_mode_i,
  input  logic                  pressed_now_i,
  input  logic [7:0]            key_code_i,
  input  kmdb_pkg::kmdb_state_t state_i,
  output kmdb_pkg::kmdb_state_t state_o,
  output kmdb_pkg::kmdb_result_t result_o
);
  import kmdb_pkg::*;

  logic signed [7:0] cnt_start;

  // Event mode restarts the count on any edge
  assign cnt_start = (state_i.prev != pressed_now_i) ? CountZero : state_i.count;

  always_comb begin
    state_o      = state_i;
    state_o.prev = pressed_now_i;
    result_o     = '0;
    if (report_mode_i) begin
      // Report mode: count up while pressed, run down after release
      if (state_i.count >= DebLimit) begin
        result_o.held = 1'b1;
        result_o.code = key_code_i;
        state_o.count = pressed_now_i ? DebHold : (state_i.count - CountOne);
      end else begin
        state_o.count = pressed_now_i ? (state_i.count + CountOne) : CountZero;
      end
    end else begin
      // Event mode: a running count that reaches the limit fires once
      state_o.count = cnt_start;
      if (!cnt_start[7]) begin
        if (cnt_start >= DebLimit) begin
          if (pressed_now_i) begin
            result_o.mk   = 1'b1;
            result_o.code = key_code_i;
            state_o.saved = key_code_i;
          end else begin
            result_o.brk  = 1'b1;
            result_o.code = state_i.saved;
          end
          state_o.count = CountIdle;
        end else begin
          state_o.count = cnt_start + CountOne;
        end
      end
    end
  end

endmodule

FILE: hdl/key_matrix_debounce_engine.sv
// Path: an accepted word is registered in stage 1, then loaded into the output
// register when stage 1 commits; out_valid_o rises with that load.
// Throughput: one word per cycle while the output is not stalled; the state RAM
// read-modify-write has a bypass for back-to-back samples of the same key.
// Reset: a clearing pass writes every key state to idle (count -1, released,
// saved code 0); no word is accepted during it.
// The mode register resets to report mode.
`timescale 1ns / 1ps

module key_matrix_debounce_engine #(
  parameter int unsigned NUM_KEYS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] key_position_i,
  input  logic       pressed_now_i,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       report_held_o,
  output logic       make_event_o,
  output logic       break_event_o,
  output logic [7:0] event_code_o
);
  import kmdb_pkg::*;

  localparam int unsigned KeyW = $clog2(NUM_KEYS);

  logic              report_mode_q;
  logic              clearing_q;
  logic [KeyW-1:0]   clr_idx_q;
  logic [KeyW-1:0]   key_idx_lut [NumPositions];
  logic [KeyW-1:0]   in_key;
  logic              in_accept;
  logic              s1_vld_q;
  logic              s1_commit;
  logic [KeyW-1:0]   s1_key_q;
  logic              s1_now_q;
  logic [7:0]        s1_code_q;
  logic              byp_q;
  kmdb_state_t       byp_state_q;
  kmdb_state_t       ram_rdata;
  kmdb_state_t       s1_state;
  kmdb_state_t       s1_next;
  kmdb_result_t      s1_result;
  logic              ram_we;
  logic [KeyW-1:0]   ram_waddr;
  kmdb_state_t       ram_wdata;
  logic              out_vld_q;
  kmdb_result_t      out_q;

  // Map each position to a key index, modulo the key count
  for (genvar g = 0; g < NumPositions; g++) begin : g_key_lut
    assign key_idx_lut[g] = KeyW'(g % NUM_KEYS);
  end
  assign in_key = key_idx_lut[key_position_i];

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      report_mode_q <= cfg_wdata_i;
    end
  end

  // Sweep the state RAM to idle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + KeyW'(1);
      if (clr_idx_q == KeyW'(NUM_KEYS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Handshake: stage 1 frees when its word moves to the output register
  assign s1_commit  = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_vld_q || s1_commit);
  assign in_accept  = in_valid_i && in_ready_o;

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_commit) begin
      s1_vld_q <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_key_q  <= in_key;
      s1_now_q  <= pressed_now_i;
      s1_code_q <= key_code_i;
    end
  end

  // Forward the committing state when the next word hits the same key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_accept) begin
      byp_q <= s1_commit && (s1_key_q == in_key);
    end else if (s1_commit) begin
      byp_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_state_q <= s1_next;
    end
  end

  assign s1_state = byp_q ? byp_state_q : ram_rdata;

  // Write port: clearing pass, then committed updates
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = StateReset;
    end else begin
      ram_we    = s1_commit;
      ram_waddr = s1_key_q;
      ram_wdata = s1_next;
    end
  end

  kmdb_state_ram #(
    .Depth (NUM_KEYS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_key),
    .rdata_o (ram_rdata)
  );

  kmdb_step u_step (
    .report_mode_i (report_mode_q),
    .pressed_now_i (s1_now_q),
    .key_code_i    (s1_code_q),
    .state_i       (s1_state),
    .state_o       (s1_next),
    .result_o      (s1_result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_commit) begin
      out_q <= s1_result;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign report_held_o = out_q.held;
  assign make_event_o  = out_q.mk;
  assign break_event_o = out_q.brk;
  assign event_code_o  = out_q.code;

`ifndef SYNTHESIS
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot0({out_q.held, out_q.mk, out_q.brk}))
    else $error("more than one result flag set");

  a_quiet_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.held && !out_q.mk && !out_q.brk) |-> (out_q.code == '0))
    else $error("quiet word carries a code");

  a_byp_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_vld_q)
    else $error("bypass set without a word in stage 1");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_vld_q && !out_vld_q))
    else $error("word in flight during clearing pass");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_vld_q)
    else $error("accepted word missing from stage 1");
`endif

endmodule
